/* design/cmrb_pkg.sv */
// Shared types, constants and helpers for the multichannel capture ring.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cmrb_pkg;

    // Ring geometry.
    localparam int BUFFER_DEPTH  = 256;
    localparam int CHANNEL_COUNT = 9;
    localparam int HALF_DEPTH    = BUFFER_DEPTH / 2;
    localparam int IDX_W         = $clog2(BUFFER_DEPTH);
    localparam int CNT_W         = $clog2(BUFFER_DEPTH + 1);
    localparam int CH_SEL_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // Decimation divider after reset.
    localparam logic [7:0] DIV_RESET = 8'd1;

    // Function codes of an input item.
    localparam logic [2:0] FUNC_SAMPLE = 3'd0;
    localparam logic [2:0] FUNC_PAUSE  = 3'd1;
    localparam logic [2:0] FUNC_HALF   = 3'd2;
    localparam logic [2:0] FUNC_RESUME = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    // One input item.
    typedef struct packed {
        logic [2:0]         func;
        logic signed [15:0] sample_ua;
        logic signed [15:0] sample_ub;
        logic signed [15:0] sample_uc;
        logic signed [15:0] sample_ia;
        logic signed [15:0] sample_ib;
        logic signed [15:0] sample_ic;
        logic signed [15:0] sample_urot;
        logic signed [15:0] sample_irot;
        logic signed [15:0] sample_iexc;
        logic [3:0]         read_channel;
        logic [8:0]         read_index;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [15:0] read_value;
        logic [8:0]         stored_count;
        logic               full_res;
        logic               paused;
        logic [7:0]         oldest_index;
        logic [7:0]         half_index;
        logic [7:0]         newest_index;
    } t_out_item;

    // Ring status after an item's effect.
    typedef struct packed {
        logic [8:0] stored_count;
        logic       full_res;
        logic       paused;
        logic [7:0] oldest_index;
        logic [7:0] half_index;
        logic [7:0] newest_index;
    } t_status;

    // Write of one point into all channel banks.
    typedef struct packed {
        logic                               en;
        logic [IDX_W-1:0]                   addr;
        logic [CHANNEL_COUNT-1:0][15:0]     data;
    } t_wr;

    // Read request for one stored value.
    typedef struct packed {
        logic                ok;
        logic [CH_SEL_W-1:0] ch;
        logic [IDX_W-1:0]    addr;
    } t_rd;

    // Ring position sum, wrapped once at the depth.
    function automatic logic [31:0] wrap_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        r = a + b;
        if (r >= 32'(BUFFER_DEPTH)) begin
            r = r - 32'(BUFFER_DEPTH);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/cmrb_ctrl.sv */
// Ring control: decimator, write index, point count and pause mark.
// Depends on cmrb_pkg; drives the sample banks and the status of each item.
`default_nettype none

module cmrb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_data,
    input  wire logic              i_in_acc,
    input  wire cmrb_pkg::t_in_item i_in_item,
    output cmrb_pkg::t_wr          o_wr,
    output cmrb_pkg::t_rd          o_rd,
    output cmrb_pkg::t_status      o_status
);

    logic [7:0]                     r_div;
    logic [cmrb_pkg::IDX_W-1:0]     r_widx, n_widx;
    logic [cmrb_pkg::CNT_W-1:0]     r_count, n_count;
    logic [cmrb_pkg::CNT_W-1:0]     r_pause, n_pause;
    logic [7:0]                     r_skip, n_skip;
    logic [8:0][15:0]               all_samples;
    logic [31:0]                    widx32, start32, half32, end32, count32, ch32, ix32;

    // Channel values in channel order.
    assign all_samples[0] = i_in_item.sample_ua;
    assign all_samples[1] = i_in_item.sample_ub;
    assign all_samples[2] = i_in_item.sample_uc;
    assign all_samples[3] = i_in_item.sample_ia;
    assign all_samples[4] = i_in_item.sample_ib;
    assign all_samples[5] = i_in_item.sample_ic;
    assign all_samples[6] = i_in_item.sample_urot;
    assign all_samples[7] = i_in_item.sample_irot;
    assign all_samples[8] = i_in_item.sample_iexc;

    // Next state for the accepted item, and the point write it causes.
    always_comb begin
        widx32    = 32'(r_widx);
        n_widx    = r_widx;
        n_count   = r_count;
        n_pause   = r_pause;
        n_skip    = r_skip;
        o_wr.en   = 1'b0;
        o_wr.addr = r_widx;
        o_wr.data = all_samples[cmrb_pkg::CHANNEL_COUNT-1:0];
        if (i_in_acc) begin
            unique case (i_in_item.func)
                cmrb_pkg::FUNC_SAMPLE: begin
                    n_skip = r_skip + 8'd1;
                    if (r_skip >= r_div) begin
                        n_skip = 8'd0;
                        if (widx32 != 32'(r_pause)) begin
                            o_wr.en = 1'b1;
                            n_widx  = cmrb_pkg::IDX_W'(cmrb_pkg::wrap_add(widx32, 32'd1));
                            if (32'(r_count) < 32'(cmrb_pkg::BUFFER_DEPTH)) begin
                                n_count = cmrb_pkg::CNT_W'(32'(r_count) + 32'd1);
                            end
                        end
                    end
                end
                cmrb_pkg::FUNC_PAUSE: begin
                    n_pause = cmrb_pkg::CNT_W'(widx32);
                end
                cmrb_pkg::FUNC_HALF: begin
                    n_pause = cmrb_pkg::CNT_W'(
                        cmrb_pkg::wrap_add(widx32, 32'(cmrb_pkg::HALF_DEPTH)));
                end
                cmrb_pkg::FUNC_RESUME: begin
                    n_pause = cmrb_pkg::CNT_W'(cmrb_pkg::BUFFER_DEPTH);
                end
                default: begin
                end
            endcase
        end
    end

    // Read request; an out-of-range channel or index reads as zero.
    always_comb begin
        ch32 = 32'(i_in_item.read_channel);
        ix32 = 32'(i_in_item.read_index);
        o_rd.ok   = (i_in_item.func == cmrb_pkg::FUNC_READ)
                 && (ch32 < 32'(cmrb_pkg::CHANNEL_COUNT))
                 && (ix32 < 32'(cmrb_pkg::BUFFER_DEPTH));
        o_rd.ch   = ch32[cmrb_pkg::CH_SEL_W-1:0];
        o_rd.addr = ix32[cmrb_pkg::IDX_W-1:0];
    end

    // Status after the item's effect.
    always_comb begin
        count32 = 32'(n_count);
        start32 = (32'(n_pause) < 32'(cmrb_pkg::BUFFER_DEPTH)) ? 32'(n_pause) : 32'(n_widx);
        half32  = cmrb_pkg::wrap_add(start32, 32'(cmrb_pkg::HALF_DEPTH));
        end32   = cmrb_pkg::wrap_add(start32, 32'(cmrb_pkg::BUFFER_DEPTH - 1));
        o_status.stored_count = count32[8:0];
        o_status.full_res     = (count32 == 32'(cmrb_pkg::BUFFER_DEPTH));
        o_status.paused       = (32'(n_widx) == 32'(n_pause));
        o_status.oldest_index = start32[7:0];
        o_status.half_index   = half32[7:0];
        o_status.newest_index = end32[7:0];
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= cmrb_pkg::DIV_RESET;
            r_widx  <= '0;
            r_count <= '0;
            r_pause <= cmrb_pkg::CNT_W'(cmrb_pkg::BUFFER_DEPTH);
            r_skip  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_div <= i_cfg_data;
            end
            r_widx  <= n_widx;
            r_count <= n_count;
            r_pause <= n_pause;
            r_skip  <= n_skip;
        end
    end

endmodule

`default_nettype wire

/* design/cmrb_store.sv */
// Sample store: one bank per channel, all written at one index per point.
// Depends on cmrb_pkg; read data is registered and selected by channel.
`default_nettype none

module cmrb_store (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cmrb_pkg::t_wr i_wr,
    input  wire logic          i_rd_en,
    input  wire cmrb_pkg::t_rd i_rd,
    output logic signed [15:0] o_rd_value
);

    logic [cmrb_pkg::CHANNEL_COUNT-1:0][15:0] bank_q;
    logic                                     r_rd_ok;
    logic [cmrb_pkg::CH_SEL_W-1:0]            r_rd_ch;

    // One memory bank per channel.
    for (genvar c = 0; c < cmrb_pkg::CHANNEL_COUNT; c++) begin : g_bank
        logic [15:0] mem [cmrb_pkg::BUFFER_DEPTH];
        logic [15:0] r_q;

        always_ff @(posedge i_clk) begin
            if (i_wr.en) begin
                mem[i_wr.addr] <= i_wr.data[c];
            end
            if (i_rd_en) begin
                r_q <= mem[i_rd.addr];
            end
        end

        assign bank_q[c] = r_q;
    end

    // Channel select and range flag travel with the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
            r_rd_ch <= '0;
        end else if (i_rd_en) begin
            r_rd_ok <= i_rd.ok;
            r_rd_ch <= i_rd.ch;
        end
    end

    assign o_rd_value = r_rd_ok ? bank_q[r_rd_ch] : 16'sd0;

endmodule

`default_nettype wire

/* design/cmrb_outq.sv */
// Two-stage result queue: the read stage, then the output register.
// Depends on cmrb_pkg; takes status at acceptance and read data when the read stage moves on.
`default_nettype none

module cmrb_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_acc,
    input  wire cmrb_pkg::t_status i_status,
    input  wire logic signed [15:0] i_rd_value,
    input  wire logic             i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output cmrb_pkg::t_out_item   o_out_item
);

    logic                 r_a_v;
    cmrb_pkg::t_status    r_a_status;
    logic                 r_b_v;
    cmrb_pkg::t_out_item  r_b_item;
    logic                 a_move;

    // The read stage moves on when the output register is free or drains.
    assign a_move     = r_a_v && (!r_b_v || i_out_ready);
    assign o_in_ready = !r_a_v || !r_b_v || i_out_ready;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (i_in_acc) begin
                r_a_v <= 1'b1;
            end else if (a_move) begin
                r_a_v <= 1'b0;
            end
            if (a_move) begin
                r_b_v <= 1'b1;
            end else if (i_out_ready) begin
                r_b_v <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_acc) begin
            r_a_status <= i_status;
        end
        if (a_move) begin
            r_b_item.read_value   <= i_rd_value;
            r_b_item.stored_count <= r_a_status.stored_count;
            r_b_item.full_res     <= r_a_status.full_res;
            r_b_item.paused       <= r_a_status.paused;
            r_b_item.oldest_index <= r_a_status.oldest_index;
            r_b_item.half_index   <= r_a_status.half_index;
            r_b_item.newest_index <= r_a_status.newest_index;
        end
    end

    assign o_out_valid = r_b_v;
    assign o_out_item  = r_b_item;

endmodule

`default_nettype wire

/* design/multichannel_capture_ring_buffer.sv */
// Top level of the nine-channel capture ring with decimator and pause mark.
// Depends on cmrb_pkg, cmrb_ctrl, cmrb_store and cmrb_outq.
//
//  Channel   Signals                             Carries
//  input     i_in_valid  o_in_ready  i_in_item   t_in_item: function, samples, read address
//  output    o_out_valid i_out_ready o_out_item  t_out_item: read value and ring status
//  config    i_cfg_valid o_cfg_ready i_cfg_data  decimation divider, always ready
//
// One item is accepted per cycle while the input is ready. Its result passes through the
// registered read of the channel banks, then the output register, before it is offered.
// The result queue holds two items: while one result waits, one more item is accepted,
// and the input stalls only when both are held and the output is not ready.
// Reset (synchronous, active low) sets the divider to one and clears the indices, count,
// pause mark and queue; the sample banks are not cleared, and no clearing pass is run.
`default_nettype none

module multichannel_capture_ring_buffer (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire cmrb_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output cmrb_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [7:0]          i_cfg_data
);

    logic               in_acc;
    cmrb_pkg::t_wr      wr;
    cmrb_pkg::t_rd      rd;
    cmrb_pkg::t_status  status;
    logic signed [15:0] rd_value;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    // Ring control.
    cmrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_acc   (in_acc),
        .i_in_item  (i_in_item),
        .o_wr       (wr),
        .o_rd       (rd),
        .o_status   (status)
    );

    // Channel banks.
    cmrb_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_rd_en    (in_acc),
        .i_rd       (rd),
        .o_rd_value (rd_value)
    );

    // Result queue.
    cmrb_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_acc    (in_acc),
        .i_status    (status),
        .i_rd_value  (rd_value),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // A read of a channel beyond the last one yields zero in the read stage.
    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_item.func == cmrb_pkg::FUNC_READ)
        && (32'(i_in_item.read_channel) >= 32'(cmrb_pkg::CHANNEL_COUNT))
        |=> (rd_value == 16'sd0))
        else $error("out-of-range channel read returned nonzero data");

    // The point count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_item.stored_count) <= 32'(cmrb_pkg::BUFFER_DEPTH)))
        else $error("stored count above depth");

    // Input stalls only while a finished result is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled with no waiting result");

    // The newest position sits just before the oldest one in the ring.
    a_newest_before_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.newest_index == 8'(o_out_item.oldest_index - 8'd1)))
        else $error("newest position does not precede the oldest one");

endmodule

`default_nettype wire
